/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the matrix-vector product.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cmvp_pkg.sv */
// Package with the types, constants and helpers of the complex matrix-vector product.
package cmvp_pkg;

  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 64;
  localparam int unsigned InW        = 16;
  localparam int unsigned ProdW      = 2 * InW;
  localparam int unsigned AccW       = 40;
  localparam int unsigned RowIdxW    = 6;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned InDataW    = 4 * InW;
  localparam int unsigned OutDataW   = 88;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic emit;
    logic first_col;
    logic last_col;
    logic last_row;
  } ctl_t;

  typedef logic signed [AccW-1:0] acc_t;

  function automatic acc_t sat_acc(input logic signed [AccW:0] v);
    acc_t res;
    if (v[AccW] != v[AccW-1]) begin
      res = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      res = v[AccW-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/complex_matrix_vector_product.sv */
// Top level of the streaming complex matrix-vector product b = A*x over a chain of row cells.
// Each item passes two multiplier stages, one register per row cell and one output
// register before its result leaves; a stall holds it longer on the way.
// Throughput: one item per cycle; the whole chain advances together and halts only while
// the output register holds a result that is not taken.
// Reset clears the counters, the chain valid flags and sets both sizes to one.
`include "assert_macros.svh"

module complex_matrix_vector_product #(
  parameter int unsigned MAX_ROWS = cmvp_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = cmvp_pkg::MaxColsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmvp_pkg::ApbAddrW-1:0]     paddr,
  input  logic [cmvp_pkg::ApbDataW-1:0]     pwdata,
  output logic [cmvp_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: a_re[15:0], a_im[31:16], x_re[47:32], x_im[63:48].
  input  logic [cmvp_pkg::InDataW-1:0]      s_axis_tdata,
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: b_re[39:0], b_im[79:40], row_index[85:80], zero pad[87:86].
  output logic [cmvp_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [cmvp_pkg::CfgW-1:0] num_rows_q, num_rows_d, num_cols_q, num_cols_d;
  logic [RowW-1:0]           nrm1_q, nrm1_d, row_q, row_d, rows_eff_m1;
  logic [ColW-1:0]           ncm1_q, ncm1_d, col_q, col_d, cols_eff_m1;
  logic [cmvp_pkg::CfgW-1:0] wval;
  logic                      cfg_wr, accept, adv;
  logic                      is_last_row, is_last_col;
  cmvp_pkg::reg_idx_e        reg_idx;
  cmvp_pkg::ctl_t            ctl_in;

  cmvp_pkg::ctl_t            ctl_c [MAX_ROWS+1];
  logic [RowW-1:0]           row_c [MAX_ROWS+1];
  cmvp_pkg::acc_t            re_c  [MAX_ROWS+1];
  cmvp_pkg::acc_t            im_c  [MAX_ROWS+1];

  logic                          out_valid_q, out_valid_d;
  logic                          out_last_q;
  logic [cmvp_pkg::RowIdxW-1:0]  out_row_q;
  cmvp_pkg::acc_t                out_re_q, out_im_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = cmvp_pkg::reg_idx_e'(paddr[2]);
  assign wval    = pwdata[cmvp_pkg::CfgW-1:0];

  always_comb begin
    if (wval == '0) begin
      rows_eff_m1 = '0;
    end else if (int'(wval) > int'(MAX_ROWS)) begin
      rows_eff_m1 = RowW'(MAX_ROWS - 1);
    end else begin
      rows_eff_m1 = RowW'(wval - cmvp_pkg::CfgW'(1));
    end
    if (wval == '0) begin
      cols_eff_m1 = '0;
    end else if (int'(wval) > int'(MAX_COLS)) begin
      cols_eff_m1 = ColW'(MAX_COLS - 1);
    end else begin
      cols_eff_m1 = ColW'(wval - cmvp_pkg::CfgW'(1));
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      cmvp_pkg::REG_NUM_ROWS: prdata = cmvp_pkg::ApbDataW'(num_rows_q);
      cmvp_pkg::REG_NUM_COLS: prdata = cmvp_pkg::ApbDataW'(num_cols_q);
      default:                prdata = '0;
    endcase
  end

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_last_row   = (row_q == nrm1_q);
  assign is_last_col   = (col_q == ncm1_q);

  always_comb begin
    num_rows_d = num_rows_q;
    num_cols_d = num_cols_q;
    nrm1_d     = nrm1_q;
    ncm1_d     = ncm1_q;
    row_d      = row_q;
    col_d      = col_q;
    if (cfg_wr) begin
      row_d = '0;
      col_d = '0;
      unique case (reg_idx)
        cmvp_pkg::REG_NUM_ROWS: begin
          num_rows_d = wval;
          nrm1_d     = rows_eff_m1;
        end
        cmvp_pkg::REG_NUM_COLS: begin
          num_cols_d = wval;
          ncm1_d     = cols_eff_m1;
        end
        default: begin
          num_rows_d = num_rows_q;
        end
      endcase
    end else if (accept) begin
      if (is_last_row) begin
        row_d = '0;
        col_d = is_last_col ? '0 : col_q + ColW'(1);
      end else begin
        row_d = row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= cmvp_pkg::CfgW'(1);
      num_cols_q <= cmvp_pkg::CfgW'(1);
      nrm1_q     <= '0;
      ncm1_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      num_rows_q <= num_rows_d;
      num_cols_q <= num_cols_d;
      nrm1_q     <= nrm1_d;
      ncm1_q     <= ncm1_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  always_comb begin
    ctl_in.valid     = accept;
    ctl_in.emit      = 1'b0;
    ctl_in.first_col = (col_q == '0);
    ctl_in.last_col  = is_last_col;
    ctl_in.last_row  = is_last_row;
  end

  cmvp_cmul #(
    .RowW (RowW)
  ) u_cmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (ctl_in),
    .row_i  (row_q),
    .a_re_i (s_axis_tdata[15:0]),
    .a_im_i (s_axis_tdata[31:16]),
    .x_re_i (s_axis_tdata[47:32]),
    .x_im_i (s_axis_tdata[63:48]),
    .ctl_o  (ctl_c[0]),
    .row_o  (row_c[0]),
    .re_o   (re_c[0]),
    .im_o   (im_c[0])
  );

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    cmvp_cell #(
      .RowW (RowW),
      .Idx  (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl_c[k]),
      .row_i  (row_c[k]),
      .re_i   (re_c[k]),
      .im_i   (im_c[k]),
      .ctl_o  (ctl_c[k+1]),
      .row_o  (row_c[k+1]),
      .re_o   (re_c[k+1]),
      .im_o   (im_c[k+1])
    );
  end

  assign out_valid_d = ctl_c[MAX_ROWS].valid && ctl_c[MAX_ROWS].emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_re_q   <= re_c[MAX_ROWS];
      out_im_q   <= im_c[MAX_ROWS];
      out_row_q  <= cmvp_pkg::RowIdxW'(row_c[MAX_ROWS]);
      out_last_q <= ctl_c[MAX_ROWS].last_row;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_row_q, out_im_q, out_re_q};
  assign m_axis_tlast  = out_last_q;

  `ASSERT_ALWAYS(a_row_in_range, row_q <= nrm1_q, "Row counter passed the row count.")
  `ASSERT_ALWAYS(a_col_in_range, col_q <= ncm1_q, "Column counter passed the column count.")
  `ASSERT_NEXT(a_pass_wraps, accept && is_last_row && is_last_col && !cfg_wr,
               row_q == '0 && col_q == '0, "Counters did not return to zero at pass end.")

endmodule

/* hw/rtl/cmvp_cmul.sv */
// Two-stage complex multiplier that feeds products into the accumulator chain.
module cmvp_cmul #(
  parameter int unsigned RowW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  cmvp_pkg::ctl_t                  ctl_i,
  input  logic [RowW-1:0]                 row_i,
  input  logic signed [cmvp_pkg::InW-1:0] a_re_i,
  input  logic signed [cmvp_pkg::InW-1:0] a_im_i,
  input  logic signed [cmvp_pkg::InW-1:0] x_re_i,
  input  logic signed [cmvp_pkg::InW-1:0] x_im_i,
  output cmvp_pkg::ctl_t                  ctl_o,
  output logic [RowW-1:0]                 row_o,
  output cmvp_pkg::acc_t                  re_o,
  output cmvp_pkg::acc_t                  im_o
);

  cmvp_pkg::ctl_t                    ctl1_q, ctl2_q;
  logic [RowW-1:0]                   row1_q, row2_q;
  logic signed [cmvp_pkg::ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  cmvp_pkg::acc_t                    re_q, im_q;
  cmvp_pkg::acc_t                    re_d, im_d;

  always_comb begin
    re_d = cmvp_pkg::acc_t'(p_rr_q) - cmvp_pkg::acc_t'(p_ii_q);
    im_d = cmvp_pkg::acc_t'(p_ri_q) + cmvp_pkg::acc_t'(p_ir_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      row1_q <= row_i;
      p_rr_q <= cmvp_pkg::ProdW'(a_re_i) * cmvp_pkg::ProdW'(x_re_i);
      p_ii_q <= cmvp_pkg::ProdW'(a_im_i) * cmvp_pkg::ProdW'(x_im_i);
      p_ri_q <= cmvp_pkg::ProdW'(a_re_i) * cmvp_pkg::ProdW'(x_im_i);
      p_ir_q <= cmvp_pkg::ProdW'(a_im_i) * cmvp_pkg::ProdW'(x_re_i);
      row2_q <= row1_q;
      re_q   <= re_d;
      im_q   <= im_d;
    end
  end

  assign ctl_o = ctl2_q;
  assign row_o = row2_q;
  assign re_o  = re_q;
  assign im_o  = im_q;

endmodule

/* hw/rtl/cmvp_cell.sv */
// One accumulator cell of the chain: owns a single row and passes items to its neighbor.
`include "assert_macros.svh"

module cmvp_cell #(
  parameter int unsigned RowW = 6,
  parameter int unsigned Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  cmvp_pkg::ctl_t  ctl_i,
  input  logic [RowW-1:0] row_i,
  input  cmvp_pkg::acc_t  re_i,
  input  cmvp_pkg::acc_t  im_i,
  output cmvp_pkg::ctl_t  ctl_o,
  output logic [RowW-1:0] row_o,
  output cmvp_pkg::acc_t  re_o,
  output cmvp_pkg::acc_t  im_o
);

  cmvp_pkg::ctl_t                   ctl_q, ctl_d;
  logic [RowW-1:0]                  row_q;
  cmvp_pkg::acc_t                   re_q, im_q, re_d, im_d;
  cmvp_pkg::acc_t                   acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic signed [cmvp_pkg::AccW:0]   sum_re, sum_im;
  logic                             hit;

  always_comb begin
    hit = ctl_i.valid && (row_i == RowW'(Idx));
    if (ctl_i.first_col) begin
      sum_re = (cmvp_pkg::AccW+1)'(re_i);
      sum_im = (cmvp_pkg::AccW+1)'(im_i);
    end else begin
      sum_re = (cmvp_pkg::AccW+1)'(acc_re_q) + (cmvp_pkg::AccW+1)'(re_i);
      sum_im = (cmvp_pkg::AccW+1)'(acc_im_q) + (cmvp_pkg::AccW+1)'(im_i);
    end
    acc_re_d = cmvp_pkg::sat_acc(sum_re);
    acc_im_d = cmvp_pkg::sat_acc(sum_im);
    ctl_d    = ctl_i;
    re_d     = re_i;
    im_d     = im_i;
    if (hit && ctl_i.last_col) begin
      ctl_d.emit = 1'b1;
      re_d       = acc_re_d;
      im_d       = acc_im_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      row_q <= row_i;
      re_q  <= re_d;
      im_q  <= im_d;
      if (hit) begin
        acc_re_q <= acc_re_d;
        acc_im_q <= acc_im_d;
      end
    end
  end

  assign ctl_o = ctl_q;
  assign row_o = row_q;
  assign re_o  = re_q;
  assign im_o  = im_q;

  `ASSERT_IMPLY(a_emit_has_item, ctl_q.emit, ctl_q.valid && ctl_q.last_col,
                "Cell holds a result that does not belong to a last-column item.")

endmodule
